>>> rtl/greedy_seam_carver_defines.svh
// ----------------------------------------------------------------------------
// Greedy seam carver assertion macros
// Shared concurrent assertion forms clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GREEDY_SEAM_CARVER_DEFINES_SVH
`define GREEDY_SEAM_CARVER_DEFINES_SVH

// Same-cycle implication.
`define GSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/gsc_pkg.sv
// ----------------------------------------------------------------------------
// Greedy seam carver package
// Operation codes, register indexes, energy widths and the control bundle of
// the shared squared-difference unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gsc_pkg;

    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_FIND   = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;
    localparam logic [1:0] FUNC_REMOVE = 2'd3;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [1:0] COMP_RED   = 2'd0;
    localparam logic [1:0] COMP_GREEN = 2'd1;
    localparam logic [1:0] COMP_BLUE  = 2'd2;

    localparam int ENERGY_W = 19;
    localparam int TOTAL_W  = 25;
    localparam logic [TOTAL_W-1:0] ENERGY_MAX = 25'h1FFFFFF;

    typedef struct packed {
        logic       clear;
        logic       add;
        logic [1:0] comp;
    } gsc_acc_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/gsc_dist_acc.sv
// ----------------------------------------------------------------------------
// Squared color difference accumulator
// Adds the square of one color component difference per cycle, while add is set,
// into the energy accumulator of the pixel being evaluated; clear empties it.
// ----------------------------------------------------------------------------
`default_nettype none

module gsc_dist_acc (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gsc_pkg::gsc_acc_ctrl_t        ctrl,
    input  wire logic [23:0]                   pix_a,
    input  wire logic [23:0]                   pix_b,
    output logic [gsc_pkg::ENERGY_W-1:0]       energy
);

    logic [7:0]                    a_comp;
    logic [7:0]                    b_comp;
    logic [7:0]                    diff;
    logic [15:0]                   square;
    logic [gsc_pkg::ENERGY_W-1:0]  acc_reg;
    logic [gsc_pkg::ENERGY_W-1:0]  acc_next;

    always_comb
    begin
        case (ctrl.comp)
            gsc_pkg::COMP_RED:
            begin
                a_comp = pix_a[23:16];
                b_comp = pix_b[23:16];
            end
            gsc_pkg::COMP_GREEN:
            begin
                a_comp = pix_a[15:8];
                b_comp = pix_b[15:8];
            end
            default:
            begin
                a_comp = pix_a[7:0];
                b_comp = pix_b[7:0];
            end
        endcase
        diff   = (a_comp > b_comp) ? (a_comp - b_comp) : (b_comp - a_comp);
        square = diff * diff;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.add)
        begin
            acc_next = acc_reg + gsc_pkg::ENERGY_W'(square);
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign energy = acc_reg;

endmodule

`default_nettype wire

>>> rtl/greedy_seam_carver.sv
// ----------------------------------------------------------------------------
// Greedy seam carver
// Image store with dual-gradient energy, greedy vertical seam search, seam
// readout and seam removal, run by a sequencer around one shared unit.
// ----------------------------------------------------------------------------
// Usage: each input beat carries one request (write pixel, find seam, read
// seam row, remove seam) and produces exactly one output beat. The block
// takes a request only while idle and while its output register is free or
// being taken in the same cycle.
// A pixel write, and any refused request, finishes in the accept cycle; its
// result is registered and visible in the next cycle. A seam row read steps
// through S_RDS and S_RDO. Each pixel energy runs through a clear state, up to
// two pairs of pixel reads through the single read port of the pixel memory
// (S_RD1 to S_RD3 per pair), the shared squared-difference unit once per
// color component of each pair and a capture state. A find evaluates up to 3
// energies per row for every start column, then copies the winning seam row
// by row (S_F_CPR, S_F_CPW). A removal reads and writes each shifted pixel
// (S_RM_RD, S_RM_WR) once the seam column of its row is read (S_RM_SEAM).
// Reset clears the sequencer, the removal count and the output valid flag;
// the pixel and seam memories hold nothing defined until written.
// When the receiver stalls, the result waits in the output register and no
// new request is taken until it has gone.
// Configuration writes must be issued only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "greedy_seam_carver_defines.svh"

module greedy_seam_carver #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [5:0]  column,
    input  wire logic [5:0]  row_index,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [5:0]       seam_column,
    output logic [24:0]      total_energy,
    output logic [6:0]       active_width,
    output logic             bad_request
);

    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int EW   = gsc_pkg::ENERGY_W;
    localparam int SUMW = EW + RW;
    localparam int CMPW = (SUMW > gsc_pkg::TOTAL_W) ? SUMW : gsc_pkg::TOTAL_W;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_RDS     = 5'd1;
    localparam logic [4:0] S_RDO     = 5'd2;
    localparam logic [4:0] S_EN_X    = 5'd3;
    localparam logic [4:0] S_EN_Y    = 5'd4;
    localparam logic [4:0] S_RD1     = 5'd5;
    localparam logic [4:0] S_RD2     = 5'd6;
    localparam logic [4:0] S_RD3     = 5'd7;
    localparam logic [4:0] S_MUL     = 5'd8;
    localparam logic [4:0] S_T_ROW   = 5'd9;
    localparam logic [4:0] S_T_GOT   = 5'd10;
    localparam logic [4:0] S_T_DEC   = 5'd11;
    localparam logic [4:0] S_T_END   = 5'd12;
    localparam logic [4:0] S_F_OUT   = 5'd13;
    localparam logic [4:0] S_RM_ROW  = 5'd14;
    localparam logic [4:0] S_RM_SEAM = 5'd15;
    localparam logic [4:0] S_RM_RD   = 5'd16;
    localparam logic [4:0] S_RM_WR   = 5'd17;
    localparam logic [4:0] S_F_CPR   = 5'd18;
    localparam logic [4:0] S_F_CPW   = 5'd19;

    localparam logic [1:0] TGT_MID   = 2'd0;
    localparam logic [1:0] TGT_RIGHT = 2'd1;
    localparam logic [1:0] TGT_LEFT  = 2'd2;

    localparam logic [1:0] BANK_SEAM = 2'b10;

    logic [23:0] pix_mem [MAX_HEIGHT * (2 ** CW)];
    logic [CW-1:0] seam_mem [3 * (2 ** RW)];

    logic [4:0]     state_reg, state_next;
    logic [CW-1:0]  c_reg, c_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [RW-1:0]  j_reg, j_next;
    logic [CW-1:0]  k_reg, k_next;
    logic [CW-1:0]  ecol_reg, ecol_next;
    logic [1:0]     tgt_reg, tgt_next;
    logic           phase_reg, phase_next;
    logic [1:0]     comp_reg, comp_next;
    logic [EW-1:0]  em_reg, em_next;
    logic [EW-1:0]  ep_reg, ep_next;
    logic [EW-1:0]  en_reg, en_next;
    logic [SUMW-1:0] sum_reg, sum_next;
    logic [SUMW-1:0] best_reg, best_next;
    logic [CW-1:0]  bestcol_reg, bestcol_next;
    logic           sel_reg, sel_next;
    logic [WW-1:0]  removed_reg, removed_next;
    logic [6:0]     width_cfg_reg;
    logic [6:0]     height_cfg_reg;
    logic [23:0]    pa_reg, pa_next;
    logic [23:0]    pb_reg, pb_next;

    logic           out_valid_reg, out_valid_next;
    logic [5:0]     seam_col_reg, seam_col_next;
    logic [24:0]    total_reg, total_next;
    logic [6:0]     width_out_reg, width_out_next;
    logic           bad_reg, bad_next;

    logic [23:0]    pix_rd_reg;
    logic [CW-1:0]  seam_rd_reg;

    logic                 pix_we;
    logic [RW+CW-1:0]     pix_waddr;
    logic [23:0]          pix_wdata;
    logic [RW+CW-1:0]     pix_raddr;
    logic                 seam_we;
    logic [RW+1:0]        seam_waddr;
    logic [CW-1:0]        seam_wdata;
    logic [RW+1:0]        seam_raddr;

    logic [10:0]    w_raw;
    logic [10:0]    h_raw;
    logic [10:0]    w_clamp;
    logic [10:0]    h_clamp;
    logic [WW-1:0]  cur_w;
    logic [HW-1:0]  cur_h;
    logic           accept;

    logic [CW-1:0]  col_l, col_r;
    logic [RW-1:0]  row_u, row_d;
    logic [RW+CW-1:0] addr1, addr2;
    logic           has_l, has_r;
    logic [CW-1:0]  dec_i;
    logic [EW-1:0]  dec_e;
    logic           win;
    logic [CMPW-1:0] best_ext;
    logic           width_ok;
    logic           emit_state;

    gsc_pkg::gsc_acc_ctrl_t acc_ctrl;
    logic [EW-1:0]  energy;

    gsc_dist_acc u_dist (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (acc_ctrl),
        .pix_a  (pa_reg),
        .pix_b  (pb_reg),
        .energy (energy)
    );

    assign w_raw   = 11'(width_cfg_reg);
    assign h_raw   = 11'(height_cfg_reg);
    assign w_clamp = (w_raw == 11'd0) ? 11'd1 :
                     (w_raw > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : w_raw;
    assign h_clamp = (h_raw == 11'd0) ? 11'd1 :
                     (h_raw > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : h_raw;
    assign cur_w   = (11'(removed_reg) >= w_clamp) ? WW'(1) : WW'(w_clamp - 11'(removed_reg));
    assign cur_h   = HW'(h_clamp);

    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    assign col_l = (ecol_reg == '0) ? CW'(cur_w - WW'(1)) : (ecol_reg - CW'(1));
    assign col_r = (WW'(ecol_reg) == cur_w - WW'(1)) ? '0 : (ecol_reg + CW'(1));
    assign row_u = (j_reg == '0) ? RW'(cur_h - HW'(1)) : (j_reg - RW'(1));
    assign row_d = (HW'(j_reg) == cur_h - HW'(1)) ? '0 : (j_reg + RW'(1));
    assign addr1 = phase_reg ? {row_u, ecol_reg} : {j_reg, col_l};
    assign addr2 = phase_reg ? {row_d, ecol_reg} : {j_reg, col_r};

    assign has_r = (j_reg != '0) && (cur_w > WW'(1)) && (WW'(i_reg) < cur_w - WW'(1));
    assign has_l = (j_reg != '0) && (cur_w > WW'(1)) && (i_reg != '0);

    assign best_ext = CMPW'(best_reg);

    assign width_ok   = (cur_w != '0) && (11'(cur_w) <= w_clamp);
    assign emit_state = (state_reg == S_IDLE) || (state_reg == S_RDO) ||
                        (state_reg == S_F_OUT) || (state_reg == S_RM_SEAM) ||
                        (state_reg == S_RM_WR);

    always_comb
    begin
        dec_i = i_reg;
        dec_e = em_reg;
        if (!has_l && !has_r)
        begin
            dec_i = i_reg;
            dec_e = em_reg;
        end
        else if (!has_l)
        begin
            if (ep_reg < em_reg)
            begin
                dec_i = i_reg + CW'(1);
                dec_e = ep_reg;
            end
        end
        else if (!has_r)
        begin
            if (en_reg < em_reg)
            begin
                dec_i = i_reg - CW'(1);
                dec_e = en_reg;
            end
        end
        else if (em_reg < en_reg && em_reg < ep_reg)
        begin
            dec_i = i_reg;
            dec_e = em_reg;
        end
        else if (ep_reg < em_reg && ep_reg < en_reg)
        begin
            dec_i = i_reg + CW'(1);
            dec_e = ep_reg;
        end
        else if (en_reg < em_reg && en_reg < ep_reg)
        begin
            dec_i = i_reg - CW'(1);
            dec_e = en_reg;
        end
        else if (em_reg == ep_reg || em_reg == en_reg)
        begin
            dec_i = i_reg;
            dec_e = em_reg;
        end
        else
        begin
            dec_i = i_reg + CW'(1);
            dec_e = ep_reg;
        end
    end

    assign win = (c_reg == '0) || (sum_reg < best_reg);

    always_comb
    begin
        state_next     = state_reg;
        c_next         = c_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        ecol_next      = ecol_reg;
        tgt_next       = tgt_reg;
        phase_next     = phase_reg;
        comp_next      = comp_reg;
        em_next        = em_reg;
        ep_next        = ep_reg;
        en_next        = en_reg;
        sum_next       = sum_reg;
        best_next      = best_reg;
        bestcol_next   = bestcol_reg;
        sel_next       = sel_reg;
        removed_next   = removed_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        out_valid_next = out_valid_reg && out_stall;
        seam_col_next  = seam_col_reg;
        total_next     = total_reg;
        width_out_next = width_out_reg;
        bad_next       = bad_reg;
        pix_we         = 1'b0;
        pix_waddr      = {RW'(row_index), CW'(column)};
        pix_wdata      = {red, green, blue};
        pix_raddr      = addr1;
        seam_we        = 1'b0;
        seam_waddr     = {1'b0, ~sel_reg, j_reg};
        seam_wdata     = dec_i;
        seam_raddr     = {BANK_SEAM, j_reg};
        acc_ctrl.clear = 1'b0;
        acc_ctrl.add   = 1'b0;
        acc_ctrl.comp  = comp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    seam_col_next  = '0;
                    total_next     = '0;
                    width_out_next = 7'(cur_w);
                    bad_next       = 1'b0;
                    unique case (func)
                        gsc_pkg::FUNC_WRITE:
                        begin
                            out_valid_next = 1'b1;
                            if (11'(column) >= 11'(cur_w) || 11'(row_index) >= 11'(cur_h))
                            begin
                                bad_next = 1'b1;
                            end
                            else
                            begin
                                pix_we = 1'b1;
                            end
                        end
                        gsc_pkg::FUNC_FIND:
                        begin
                            c_next     = '0;
                            i_next     = '0;
                            j_next     = '0;
                            sum_next   = '0;
                            state_next = S_T_ROW;
                        end
                        gsc_pkg::FUNC_READ:
                        begin
                            if (11'(row_index) >= 11'(cur_h))
                            begin
                                bad_next       = 1'b1;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                j_next     = RW'(row_index);
                                state_next = S_RDS;
                            end
                        end
                        gsc_pkg::FUNC_REMOVE:
                        begin
                            if (cur_w <= WW'(1))
                            begin
                                bad_next       = 1'b1;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                j_next     = '0;
                                state_next = S_RM_ROW;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RDS:
            begin
                state_next = S_RDO;
            end
            S_RDO:
            begin
                seam_col_next  = 6'(seam_rd_reg);
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_T_ROW:
            begin
                tgt_next   = TGT_MID;
                ecol_next  = i_reg;
                state_next = S_EN_X;
            end
            S_EN_X:
            begin
                acc_ctrl.clear = 1'b1;
                phase_next     = 1'b0;
                comp_next      = gsc_pkg::COMP_RED;
                state_next     = (cur_w > WW'(2)) ? S_RD1 : S_EN_Y;
            end
            S_EN_Y:
            begin
                phase_next = 1'b1;
                comp_next  = gsc_pkg::COMP_RED;
                state_next = (cur_h > HW'(2)) ? S_RD1 : S_T_GOT;
            end
            S_RD1:
            begin
                pix_raddr  = addr1;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                pix_raddr  = addr2;
                pa_next    = pix_rd_reg;
                state_next = S_RD3;
            end
            S_RD3:
            begin
                pb_next    = pix_rd_reg;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                acc_ctrl.add = 1'b1;
                comp_next    = comp_reg + 2'd1;
                if (comp_reg == gsc_pkg::COMP_BLUE)
                begin
                    state_next = phase_reg ? S_T_GOT : S_EN_Y;
                end
            end
            S_T_GOT:
            begin
                case (tgt_reg)
                    TGT_MID:   em_next = energy;
                    TGT_RIGHT: ep_next = energy;
                    default:   en_next = energy;
                endcase
                if (tgt_reg == TGT_MID && has_r)
                begin
                    tgt_next   = TGT_RIGHT;
                    ecol_next  = i_reg + CW'(1);
                    state_next = S_EN_X;
                end
                else if (tgt_reg != TGT_LEFT && has_l)
                begin
                    tgt_next   = TGT_LEFT;
                    ecol_next  = i_reg - CW'(1);
                    state_next = S_EN_X;
                end
                else
                begin
                    state_next = S_T_DEC;
                end
            end
            S_T_DEC:
            begin
                seam_we  = 1'b1;
                i_next   = dec_i;
                sum_next = sum_reg + SUMW'(dec_e);
                if (HW'(j_reg) == cur_h - HW'(1))
                begin
                    state_next = S_T_END;
                end
                else
                begin
                    j_next     = j_reg + RW'(1);
                    state_next = S_T_ROW;
                end
            end
            S_T_END:
            begin
                if (win)
                begin
                    best_next    = sum_reg;
                    bestcol_next = c_reg;
                    sel_next     = ~sel_reg;
                end
                if (WW'(c_reg) == cur_w - WW'(1))
                begin
                    j_next     = '0;
                    state_next = S_F_CPR;
                end
                else
                begin
                    c_next     = c_reg + CW'(1);
                    i_next     = c_reg + CW'(1);
                    j_next     = '0;
                    sum_next   = '0;
                    state_next = S_T_ROW;
                end
            end
            S_F_CPR:
            begin
                seam_raddr = {1'b0, sel_reg, j_reg};
                state_next = S_F_CPW;
            end
            S_F_CPW:
            begin
                seam_we    = 1'b1;
                seam_waddr = {BANK_SEAM, j_reg};
                seam_wdata = seam_rd_reg;
                if (HW'(j_reg) == cur_h - HW'(1))
                begin
                    state_next = S_F_OUT;
                end
                else
                begin
                    j_next     = j_reg + RW'(1);
                    state_next = S_F_CPR;
                end
            end
            S_F_OUT:
            begin
                seam_col_next  = 6'(bestcol_reg);
                total_next     = (best_ext > CMPW'(gsc_pkg::ENERGY_MAX)) ?
                                 gsc_pkg::ENERGY_MAX : 25'(best_ext);
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_RM_ROW:
            begin
                state_next = S_RM_SEAM;
            end
            S_RM_SEAM:
            begin
                k_next = seam_rd_reg;
                if (WW'(seam_rd_reg) + WW'(1) < cur_w)
                begin
                    state_next = S_RM_RD;
                end
                else if (HW'(j_reg) == cur_h - HW'(1))
                begin
                    removed_next   = removed_reg + WW'(1);
                    width_out_next = 7'(cur_w - WW'(1));
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    j_next     = j_reg + RW'(1);
                    state_next = S_RM_ROW;
                end
            end
            S_RM_RD:
            begin
                pix_raddr  = {j_reg, k_reg + CW'(1)};
                state_next = S_RM_WR;
            end
            S_RM_WR:
            begin
                pix_we    = 1'b1;
                pix_waddr = {j_reg, k_reg};
                pix_wdata = pix_rd_reg;
                k_next    = k_reg + CW'(1);
                if (WW'(k_reg) + WW'(2) < cur_w)
                begin
                    state_next = S_RM_RD;
                end
                else if (HW'(j_reg) == cur_h - HW'(1))
                begin
                    removed_next   = removed_reg + WW'(1);
                    width_out_next = 7'(cur_w - WW'(1));
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    j_next     = j_reg + RW'(1);
                    state_next = S_RM_ROW;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pix_we)
        begin
            pix_mem[pix_waddr] <= pix_wdata;
        end
        pix_rd_reg <= pix_mem[pix_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (seam_we)
        begin
            seam_mem[seam_waddr] <= seam_wdata;
        end
        seam_rd_reg <= seam_mem[seam_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            c_reg          <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            ecol_reg       <= '0;
            tgt_reg        <= TGT_MID;
            phase_reg      <= 1'b0;
            comp_reg       <= gsc_pkg::COMP_RED;
            sum_reg        <= '0;
            best_reg       <= '0;
            sel_reg        <= 1'b0;
            removed_reg    <= '0;
            width_cfg_reg  <= 7'd64;
            height_cfg_reg <= 7'd64;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            c_reg         <= c_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            ecol_reg      <= ecol_next;
            tgt_reg       <= tgt_next;
            phase_reg     <= phase_next;
            comp_reg      <= comp_next;
            sum_reg       <= sum_next;
            best_reg      <= best_next;
            sel_reg       <= sel_next;
            removed_reg   <= removed_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en && cfg_index == gsc_pkg::REG_IMAGE_WIDTH)
            begin
                width_cfg_reg <= cfg_data;
            end
            if (cfg_write_en && cfg_index == gsc_pkg::REG_IMAGE_HEIGHT)
            begin
                height_cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        em_reg        <= em_next;
        ep_reg        <= ep_next;
        en_reg        <= en_next;
        bestcol_reg   <= bestcol_next;
        pa_reg        <= pa_next;
        pb_reg        <= pb_next;
        seam_col_reg  <= seam_col_next;
        total_reg     <= total_next;
        width_out_reg <= width_out_next;
        bad_reg       <= bad_next;
    end

    assign out_valid    = out_valid_reg;
    assign seam_column  = seam_col_reg;
    assign total_energy = total_reg;
    assign active_width = width_out_reg;
    assign bad_request  = bad_reg;

    `GSC_ASSERT_NOW(a_accept_idle, accept, state_reg == S_IDLE, "request taken while busy")
    `GSC_ASSERT_NOW(a_width_range, 1'b1, width_ok, "active width out of range")
    `GSC_ASSERT_NOW(a_seam_inside, state_reg == S_T_DEC, WW'(dec_i) < cur_w, "seam step left")
    `GSC_ASSERT_NEXT(a_busy_no_out, !emit_state && !out_valid_reg, !out_valid_reg, "early result")

endmodule

`default_nettype wire
